// File: hw/rtl/two_region_bump_allocator_unit_assert.svh
// Assertion macros for the two-region bump allocator.
// Used by the top level; no other dependencies.
`ifndef TWO_REGION_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`define TWO_REGION_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define TRBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
// Next-cycle implication, disabled during reset.
`define TRBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define TRBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TRBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/trba_pkg.sv
// Shared types and action codes for the two-region bump allocator.
// No dependencies.
package trba_pkg;

    localparam logic [2:0] ACT_ALLOC     = 3'd0;
    localparam logic [2:0] ACT_FREE      = 3'd1;
    localparam logic [2:0] ACT_SAVE      = 3'd2;
    localparam logic [2:0] ACT_RESTORE   = 3'd3;
    localparam logic [2:0] ACT_RESET_OVF = 3'd4;
    localparam logic [2:0] ACT_STATUS    = 3'd5;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] request_size;
        logic [15:0] free_address;
    } t_item;

    typedef struct packed {
        logic        granted;
        logic [15:0] block_address;
        logic [15:0] used_bytes;
        logic [15:0] high_water;
        logic [31:0] fail_count;
        logic [31:0] alloc_count;
        logic [16:0] largest_failed;
        logic [31:0] reclaim_count;
    } t_result;

endpackage

// File: hw/rtl/trba_core.sv
// Allocator state registers and the single-pass next-state and result logic.
// Depends on trba_pkg.
module trba_core #(
    parameter int PRIMARY_BYTES  = 32768,
    parameter int OVERFLOW_BYTES = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  trba_pkg::t_item   i_item,
    output trba_pkg::t_result o_result
);

    localparam int PW = $clog2(PRIMARY_BYTES + 1);
    localparam int OW = $clog2(OVERFLOW_BYTES + 1);
    localparam logic [17:0] PRIM_LIM = 18'(PRIMARY_BYTES);
    localparam logic [17:0] OVF_LIM  = 18'(OVERFLOW_BYTES);

    logic [PW-1:0] r_primary,  n_primary;
    logic [OW-1:0] r_overflow, n_overflow;
    logic [PW-1:0] r_baseline, n_baseline;
    logic [PW-1:0] r_peak,     n_peak;
    logic [31:0]   r_refusals, n_refusals;
    logic [31:0]   r_grants,   n_grants;
    logic [16:0]   r_biggest,  n_biggest;
    logic [31:0]   r_reclaims, n_reclaims;
    logic [15:0]   r_rec_addr, n_rec_addr;
    logic [16:0]   r_rec_size, n_rec_size;
    logic          r_rec_ovf,  n_rec_ovf;

    logic [16:0] size;
    logic [17:0] prim_sum;
    logic [17:0] ovf_sum;
    logic        granted;
    logic [15:0] addr;

    assign size     = (17'(i_item.request_size) + 17'd7) & ~17'd7;
    assign prim_sum = 18'(r_primary) + 18'(size);
    assign ovf_sum  = 18'(r_overflow) + 18'(size);

    always_comb begin
        n_primary  = r_primary;
        n_overflow = r_overflow;
        n_baseline = r_baseline;
        n_peak     = r_peak;
        n_refusals = r_refusals;
        n_grants   = r_grants;
        n_biggest  = r_biggest;
        n_reclaims = r_reclaims;
        n_rec_addr = r_rec_addr;
        n_rec_size = r_rec_size;
        n_rec_ovf  = r_rec_ovf;
        granted    = 1'b0;
        addr       = 16'd0;
        case (i_item.action)
            trba_pkg::ACT_ALLOC: begin
                if (prim_sum <= PRIM_LIM) begin
                    addr       = 16'(r_primary);
                    n_primary  = PW'(prim_sum);
                    n_grants   = r_grants + 32'd1;
                    if (PW'(prim_sum) > r_peak) begin
                        n_peak = PW'(prim_sum);
                    end
                    n_rec_addr = 16'(r_primary);
                    n_rec_size = size;
                    n_rec_ovf  = 1'b0;
                    granted    = 1'b1;
                end else if (ovf_sum <= OVF_LIM) begin
                    addr       = 16'(PRIM_LIM + 18'(r_overflow));
                    n_overflow = OW'(ovf_sum);
                    n_grants   = r_grants + 32'd1;
                    n_rec_addr = 16'(PRIM_LIM + 18'(r_overflow));
                    n_rec_size = size;
                    n_rec_ovf  = 1'b1;
                    granted    = 1'b1;
                end else begin
                    n_refusals = r_refusals + 32'd1;
                    if (size > r_biggest) begin
                        n_biggest = size;
                    end
                end
            end
            trba_pkg::ACT_FREE: begin
                if (r_rec_size != 17'd0 && i_item.free_address == r_rec_addr) begin
                    if (r_rec_ovf) begin
                        n_overflow = (18'(r_overflow) >= 18'(r_rec_size))
                                   ? OW'(18'(r_overflow) - 18'(r_rec_size)) : '0;
                    end else begin
                        n_primary = (18'(r_primary) >= 18'(r_rec_size))
                                  ? PW'(18'(r_primary) - 18'(r_rec_size)) : '0;
                    end
                    n_rec_addr = 16'd0;
                    n_rec_size = 17'd0;
                    n_rec_ovf  = 1'b0;
                    n_reclaims = r_reclaims + 32'd1;
                    granted    = 1'b1;
                end
            end
            trba_pkg::ACT_SAVE: begin
                n_baseline = r_primary;
            end
            trba_pkg::ACT_RESTORE: begin
                n_primary  = r_baseline;
                n_overflow = '0;
                n_rec_addr = 16'd0;
                n_rec_size = 17'd0;
                n_rec_ovf  = 1'b0;
            end
            trba_pkg::ACT_RESET_OVF: begin
                n_overflow = '0;
                if (r_rec_ovf) begin
                    n_rec_addr = 16'd0;
                    n_rec_size = 17'd0;
                    n_rec_ovf  = 1'b0;
                end
            end
            default: begin
                // Status and the unused codes leave the state alone.
            end
        endcase
    end

    always_comb begin
        o_result.granted        = granted;
        o_result.block_address  = addr;
        o_result.used_bytes     = 16'(18'(n_primary) + 18'(n_overflow));
        o_result.high_water     = 16'(n_peak);
        o_result.fail_count     = n_refusals;
        o_result.alloc_count    = n_grants;
        o_result.largest_failed = n_biggest;
        o_result.reclaim_count  = n_reclaims;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary  <= '0;
            r_overflow <= '0;
            r_baseline <= '0;
            r_peak     <= '0;
            r_refusals <= 32'd0;
            r_grants   <= 32'd0;
            r_biggest  <= 17'd0;
            r_reclaims <= 32'd0;
            r_rec_addr <= 16'd0;
            r_rec_size <= 17'd0;
            r_rec_ovf  <= 1'b0;
        end else if (i_valid) begin
            r_primary  <= n_primary;
            r_overflow <= n_overflow;
            r_baseline <= n_baseline;
            r_peak     <= n_peak;
            r_refusals <= n_refusals;
            r_grants   <= n_grants;
            r_biggest  <= n_biggest;
            r_reclaims <= n_reclaims;
            r_rec_addr <= n_rec_addr;
            r_rec_size <= n_rec_size;
            r_rec_ovf  <= n_rec_ovf;
        end
    end

endmodule

// File: hw/rtl/two_region_bump_allocator_unit.sv
// Top level of the two-region bump allocator: input register, core, result register.
// Depends on trba_pkg, trba_core and two_region_bump_allocator_unit_assert.svh.
//
// Usage: drive a request on i_item and raise i_start. A transfer takes place at
// every rising edge where i_start is high and o_busy is low. o_busy is always
// low, so one request may be issued in every cycle.
// Each request is an action: allocate, free, save baseline, reset to baseline,
// reset overflow, or status. Every request produces exactly one result.
// The request is captured in an input register, the
// core works out the new allocator state and the result in one pass of short
// logic (one 18-bit add and compare per region), and the result register then
// presents it. o_done is high for exactly one cycle with o_result valid in
// that cycle.
// Throughput is one request per clock; the state registers in the core are
// updated at the same edge that loads the result register, so back-to-back
// requests see each other's effects in order.
// The receiver cannot stall: a result that is not taken in its strobe cycle
// is gone. A synchronous active-low reset clears all offsets, counters and the
// record of the most recent block, and drops any request in flight.
module two_region_bump_allocator_unit #(
    parameter int PRIMARY_BYTES  = 32768,
    parameter int OVERFLOW_BYTES = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  trba_pkg::t_item   i_item,
    output logic              o_busy,
    output logic              o_done,
    output trba_pkg::t_result o_result
);

`include "two_region_bump_allocator_unit_assert.svh"

    logic              r_in_valid;
    trba_pkg::t_item   r_in;
    logic              r_done;
    trba_pkg::t_result r_result;
    trba_pkg::t_result core_result;

    // The block can always take a new request.
    assign o_busy = 1'b0;

    // Input register: the payload needs no reset, only its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
        if (i_start && !o_busy) begin
            r_in <= i_item;
        end
    end

    trba_core #(
        .PRIMARY_BYTES  (PRIMARY_BYTES),
        .OVERFLOW_BYTES (OVERFLOW_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // Result register: the strobe lasts one cycle per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
        if (r_in_valid) begin
            r_result <= core_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // A transfer in always reaches the core stage in the next cycle.
    `TRBA_ASSERT_NEXT(a_in_to_core, i_clk, i_rst_n, i_start && !o_busy, r_in_valid)
    // Every request in the core stage yields a result strobe next cycle.
    `TRBA_ASSERT_NEXT(a_core_to_done, i_clk, i_rst_n, r_in_valid, o_done)
    // Only a granted allocation reports a block address.
    `TRBA_ASSERT_IMPLY(a_addr_zero, i_clk, i_rst_n, o_done && !o_result.granted,
        o_result.block_address == 16'd0)
    // The grant counter moves by at most one between consecutive results.
    `TRBA_ASSERT_IMPLY(a_grant_step, i_clk, i_rst_n, o_done && $past(o_done),
        o_result.alloc_count == $past(o_result.alloc_count) ||
        o_result.alloc_count == 32'($past(o_result.alloc_count) + 32'd1))

endmodule
